[hdl/cpfp_pkg.sv]
// Shared types and constants for the cluster packet field parser.
package cpfp_pkg;

    // Field codes: also the parser phase, since each phase names the field it consumes
    typedef enum logic [3:0] {
        PH_KIND  = 4'd0,
        PH_SESS  = 4'd1,
        PH_NLEN  = 4'd2,
        PH_NODE  = 4'd3,
        PH_AKIND = 4'd4,
        PH_ANUM  = 4'd5,
        PH_ALEN  = 4'd6,
        PH_ANAME = 4'd7,
        PH_TYPE  = 4'd8,
        PH_SIZE  = 4'd9,
        PH_PAY   = 4'd10,
        PH_IGN   = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_KIND  = 2'd1,
        ERR_NODE  = 2'd2,
        ERR_TRUNC = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        PK_SINGLE = 2'd0,
        PK_FIRST  = 2'd1,
        PK_MIDDLE = 2'd2,
        PK_END    = 2'd3
    } t_kind;

    localparam logic [7:0] KIND_SINGLE_CODE = 8'h00;
    localparam logic [7:0] KIND_FIRST_CODE  = 8'h41;
    localparam logic [7:0] KIND_MIDDLE_CODE = 8'h42;
    localparam logic [7:0] KIND_END_CODE    = 8'h44;

    localparam logic [7:0] WORD_LAST_IDX = 8'd3;
    localparam logic [7:0] IDX_MAX       = 8'hff;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  byte_in_field;
        logic [7:0]  node_bytes_left;
        logic [7:0]  addr_bytes_left;
        logic [31:0] word_shift;
        t_kind       kind_held;
        t_err        error_held;
    } t_state;

    typedef struct packed {
        logic [3:0]  field_code;
        logic [7:0]  byte_value;
        logic [7:0]  field_index;
        logic [31:0] word_value;
        logic        word_done;
        logic [1:0]  packet_kind;
        logic        end_of_packet;
        logic [1:0]  error_code;
    } t_result;

endpackage

[hdl/cpfp_in_if.sv]
// Input byte channel: valid/ready handshake carrying one packet body byte.
interface cpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hdl/cpfp_out_if.sv]
// Result channel: valid/ready handshake carrying one field classification.
interface cpfp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_code;
    logic [7:0]  byte_value;
    logic [7:0]  field_index;
    logic [31:0] word_value;
    logic        word_done;
    logic [1:0]  packet_kind;
    logic        end_of_packet;
    logic [1:0]  error_code;

    modport source (output valid, output field_code, output byte_value, output field_index,
                    output word_value, output word_done, output packet_kind,
                    output end_of_packet, output error_code, input ready);
    modport sink   (input valid, input field_code, input byte_value, input field_index,
                    input word_value, input word_done, input packet_kind,
                    input end_of_packet, input error_code, output ready);
endinterface

[hdl/cpfp_field_decoder.sv]
// Per-byte field decode: next parser state and the result for one byte.
module cpfp_field_decoder (
    input  cpfp_pkg::t_state  i_state,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output cpfp_pkg::t_state  o_next_state,
    output cpfp_pkg::t_result o_result
);

    cpfp_pkg::t_state n_st;
    cpfp_pkg::t_err   err;
    logic [31:0]      shifted;
    logic [31:0]      word;
    logic             done;
    logic             complete;
    logic             idx_is_last;
    logic [7:0]       idx_inc;
    logic [7:0]       node_dec;
    logic [7:0]       addr_dec;
    logic             early_kind;

    always_comb begin
        shifted     = {i_data_byte, i_state.word_shift[31:8]};
        idx_is_last = (i_state.byte_in_field == cpfp_pkg::WORD_LAST_IDX);
        idx_inc     = (i_state.byte_in_field == cpfp_pkg::IDX_MAX) ?
                      i_state.byte_in_field : i_state.byte_in_field + 8'd1;
        node_dec    = i_state.node_bytes_left - 8'd1;
        addr_dec    = i_state.addr_bytes_left - 8'd1;
        early_kind  = (i_state.kind_held == cpfp_pkg::PK_SINGLE) ||
                      (i_state.kind_held == cpfp_pkg::PK_FIRST);

        n_st     = i_state;
        word     = '0;
        done     = 1'b0;
        complete = 1'b0;
        err      = cpfp_pkg::ERR_OK;

        // 32-bit fields shift in LSB first
        if (i_state.phase == cpfp_pkg::PH_SESS || i_state.phase == cpfp_pkg::PH_ANUM ||
            i_state.phase == cpfp_pkg::PH_TYPE || i_state.phase == cpfp_pkg::PH_SIZE) begin
            n_st.word_shift = shifted;
            if (idx_is_last) begin
                word = shifted;
                done = 1'b1;
            end
        end

        unique case (i_state.phase)
            cpfp_pkg::PH_KIND: begin
                n_st.byte_in_field = '0;
                n_st.phase         = cpfp_pkg::PH_SESS;
                case (i_data_byte)
                    cpfp_pkg::KIND_SINGLE_CODE: n_st.kind_held = cpfp_pkg::PK_SINGLE;
                    cpfp_pkg::KIND_FIRST_CODE:  n_st.kind_held = cpfp_pkg::PK_FIRST;
                    cpfp_pkg::KIND_MIDDLE_CODE: n_st.kind_held = cpfp_pkg::PK_MIDDLE;
                    cpfp_pkg::KIND_END_CODE:    n_st.kind_held = cpfp_pkg::PK_END;
                    default: begin
                        n_st.kind_held  = cpfp_pkg::PK_SINGLE;
                        n_st.error_held = cpfp_pkg::ERR_KIND;
                        n_st.phase      = cpfp_pkg::PH_IGN;
                    end
                endcase
            end
            cpfp_pkg::PH_SESS: begin
                if (idx_is_last) begin
                    n_st.phase         = cpfp_pkg::PH_NLEN;
                    n_st.byte_in_field = '0;
                end else begin
                    n_st.byte_in_field = idx_inc;
                end
            end
            cpfp_pkg::PH_NLEN: begin
                n_st.node_bytes_left = i_data_byte;
                n_st.byte_in_field   = '0;
                if (i_data_byte == 8'd0) begin
                    n_st.error_held = cpfp_pkg::ERR_NODE;
                    n_st.phase      = cpfp_pkg::PH_IGN;
                end else begin
                    n_st.phase = cpfp_pkg::PH_NODE;
                end
            end
            cpfp_pkg::PH_NODE: begin
                n_st.node_bytes_left = node_dec;
                if (node_dec == 8'd0) begin
                    complete           = !early_kind;
                    n_st.phase         = early_kind ? cpfp_pkg::PH_AKIND : cpfp_pkg::PH_PAY;
                    n_st.byte_in_field = '0;
                end else begin
                    n_st.byte_in_field = idx_inc;
                end
            end
            cpfp_pkg::PH_AKIND: begin
                n_st.phase = (i_data_byte == 8'd0) ? cpfp_pkg::PH_ANUM : cpfp_pkg::PH_ALEN;
                n_st.byte_in_field = '0;
            end
            cpfp_pkg::PH_ANUM: begin
                if (idx_is_last) begin
                    n_st.phase         = cpfp_pkg::PH_TYPE;
                    n_st.byte_in_field = '0;
                end else begin
                    n_st.byte_in_field = idx_inc;
                end
            end
            cpfp_pkg::PH_ALEN: begin
                n_st.addr_bytes_left = i_data_byte;
                n_st.phase = (i_data_byte == 8'd0) ? cpfp_pkg::PH_TYPE : cpfp_pkg::PH_ANAME;
                n_st.byte_in_field = '0;
            end
            cpfp_pkg::PH_ANAME: begin
                n_st.addr_bytes_left = addr_dec;
                if (addr_dec == 8'd0) begin
                    n_st.phase         = cpfp_pkg::PH_TYPE;
                    n_st.byte_in_field = '0;
                end else begin
                    n_st.byte_in_field = idx_inc;
                end
            end
            cpfp_pkg::PH_TYPE: begin
                if (idx_is_last) begin
                    complete = (i_state.kind_held == cpfp_pkg::PK_SINGLE);
                    n_st.phase = complete ? cpfp_pkg::PH_PAY : cpfp_pkg::PH_SIZE;
                    n_st.byte_in_field = '0;
                end else begin
                    n_st.byte_in_field = idx_inc;
                end
            end
            cpfp_pkg::PH_SIZE: begin
                if (idx_is_last) begin
                    complete           = 1'b1;
                    n_st.phase         = cpfp_pkg::PH_IGN;
                    n_st.byte_in_field = '0;
                end else begin
                    n_st.byte_in_field = idx_inc;
                end
            end
            default: begin
                // payload and ignored bytes
                complete           = 1'b1;
                n_st.byte_in_field = idx_inc;
            end
        endcase

        if (i_last_byte) begin
            if (i_state.phase == cpfp_pkg::PH_NLEN && i_data_byte == 8'd0) begin
                err = early_kind ? cpfp_pkg::ERR_TRUNC : cpfp_pkg::ERR_NODE;
            end else if (n_st.error_held == cpfp_pkg::ERR_KIND) begin
                err = cpfp_pkg::ERR_KIND;
            end else if (n_st.error_held == cpfp_pkg::ERR_NODE) begin
                // packet ended right after a zero node length: too short for single/first
                err = (early_kind && i_state.phase == cpfp_pkg::PH_IGN &&
                       i_state.byte_in_field == 8'd0) ? cpfp_pkg::ERR_TRUNC
                                                      : cpfp_pkg::ERR_NODE;
            end else begin
                err = complete ? cpfp_pkg::ERR_OK : cpfp_pkg::ERR_TRUNC;
            end
        end

        o_result.field_code    = i_state.phase;
        o_result.byte_value    = i_data_byte;
        o_result.field_index   = i_state.byte_in_field;
        o_result.word_value    = word;
        o_result.word_done     = done;
        o_result.packet_kind   = n_st.kind_held;
        o_result.end_of_packet = i_last_byte;
        o_result.error_code    = err;

        // every packet starts from a clean state
        if (i_last_byte) begin
            o_next_state.phase           = cpfp_pkg::PH_KIND;
            o_next_state.byte_in_field   = '0;
            o_next_state.node_bytes_left = '0;
            o_next_state.addr_bytes_left = '0;
            o_next_state.word_shift      = '0;
            o_next_state.kind_held       = cpfp_pkg::PK_SINGLE;
            o_next_state.error_held      = cpfp_pkg::ERR_OK;
        end else begin
            o_next_state = n_st;
        end
    end

endmodule

[hdl/cluster_packet_field_parser_unit.sv]
// Top level of the cluster packet field parser: input register, state and result register.
//
// Usage: packet body bytes (length header already stripped) enter on i_in, one byte per
// transaction, with last_byte set on the final byte of each packet. For every byte one
// result leaves on o_out naming the field the byte belongs to, its index in that field,
// the assembled 32-bit value on the fourth byte of a word field, the packet kind and, on
// the last byte, the error verdict.
// Path: an accepted byte is held in the input register, then decoded against the parser
// state into the result register, from which o_out offers its result to the receiver.
// Throughput: one byte per cycle sustained while o_out is not stalled; the per-byte
// combinational decode against the parser state register is the only work in the loop.
// Reset (i_rst_n low, synchronous): both stages empty, parser waits for a kind byte.
// When the receiver stalls, the result register holds its transaction; the input
// register still takes one more byte, after which i_in.ready drops until o_out drains.
// After a last byte the parser returns to its reset state on its own.
module cluster_packet_field_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpfp_in_if.sink    i_in,
    cpfp_out_if.source o_out
);

    logic              r_in_valid;
    logic [7:0]        r_data_byte;
    logic              r_last_byte;
    cpfp_pkg::t_state  r_state;
    logic              r_out_valid;
    cpfp_pkg::t_result r_result;

    cpfp_pkg::t_state  n_state;
    cpfp_pkg::t_result n_result;
    logic              step;

    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    cpfp_field_decoder u_decoder (
        .i_state      (r_state),
        .i_data_byte  (r_data_byte),
        .i_last_byte  (r_last_byte),
        .o_next_state (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data_byte <= i_in.data_byte;
            r_last_byte <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= cpfp_pkg::PH_KIND;
            r_state.byte_in_field   <= '0;
            r_state.node_bytes_left <= '0;
            r_state.addr_bytes_left <= '0;
            r_state.word_shift      <= '0;
            r_state.kind_held       <= cpfp_pkg::PK_SINGLE;
            r_state.error_held      <= cpfp_pkg::ERR_OK;
        end else if (step) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.field_code    = r_result.field_code;
    assign o_out.byte_value    = r_result.byte_value;
    assign o_out.field_index   = r_result.field_index;
    assign o_out.word_value    = r_result.word_value;
    assign o_out.word_done     = r_result.word_done;
    assign o_out.packet_kind   = r_result.packet_kind;
    assign o_out.end_of_packet = r_result.end_of_packet;
    assign o_out.error_code    = r_result.error_code;

endmodule

[test/tb.sv]
// Self-checking testbench for the cluster packet field parser: random packets, scoreboard.
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_TOGGLE, RX_HEAVY} t_rx_mode;

    // Tracks parser state per accepted byte and holds the field results still owed by the DUT.
    class parse_checker;
        cpfp_pkg::t_phase  cur_phase;
        logic [7:0]        in_field;
        logic [7:0]        node_left;
        logic [7:0]        addr_left;
        logic [31:0]       shift_word;
        cpfp_pkg::t_kind   kind;
        cpfp_pkg::t_err    held_err;
        cpfp_pkg::t_result expected_fields[$];
        int                mismatch_count;

        function new();
            mismatch_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            cur_phase  = cpfp_pkg::PH_KIND;
            in_field   = 8'd0;
            node_left  = 8'd0;
            addr_left  = 8'd0;
            shift_word = 32'd0;
            kind       = cpfp_pkg::PK_SINGLE;
            held_err   = cpfp_pkg::ERR_OK;
        endfunction

        function void enter_phase(cpfp_pkg::t_phase next);
            cur_phase = next;
            in_field  = 8'd0;
        endfunction

        function void bump_index();
            if (in_field != cpfp_pkg::IDX_MAX)
                in_field = in_field + 8'd1;
        endfunction

        function cpfp_pkg::t_result classify_byte(logic [7:0] b, logic last);
            cpfp_pkg::t_result r;
            cpfp_pkg::t_phase  field;
            logic [7:0]        idx;
            bit                complete;
            bit                is_frag;
            r        = '0;
            field    = cur_phase;
            idx      = in_field;
            complete = 1'b0;

            if (field == cpfp_pkg::PH_SESS || field == cpfp_pkg::PH_ANUM ||
                field == cpfp_pkg::PH_TYPE || field == cpfp_pkg::PH_SIZE) begin
                shift_word = {b, shift_word[31:8]};
                if (idx == cpfp_pkg::WORD_LAST_IDX) begin
                    r.word_value = shift_word;
                    r.word_done  = 1'b1;
                end
            end

            case (field)
                cpfp_pkg::PH_KIND: begin
                    case (b)
                        cpfp_pkg::KIND_SINGLE_CODE: kind = cpfp_pkg::PK_SINGLE;
                        cpfp_pkg::KIND_FIRST_CODE:  kind = cpfp_pkg::PK_FIRST;
                        cpfp_pkg::KIND_MIDDLE_CODE: kind = cpfp_pkg::PK_MIDDLE;
                        cpfp_pkg::KIND_END_CODE:    kind = cpfp_pkg::PK_END;
                        default: begin
                            kind     = cpfp_pkg::PK_SINGLE;
                            held_err = cpfp_pkg::ERR_KIND;
                        end
                    endcase
                    enter_phase((held_err != cpfp_pkg::ERR_OK) ? cpfp_pkg::PH_IGN
                                                               : cpfp_pkg::PH_SESS);
                end
                cpfp_pkg::PH_SESS: begin
                    if (idx == cpfp_pkg::WORD_LAST_IDX) enter_phase(cpfp_pkg::PH_NLEN);
                    else bump_index();
                end
                cpfp_pkg::PH_NLEN: begin
                    node_left = b;
                    if (b == 8'd0) begin
                        held_err = cpfp_pkg::ERR_NODE;
                        enter_phase(cpfp_pkg::PH_IGN);
                    end else begin
                        enter_phase(cpfp_pkg::PH_NODE);
                    end
                end
                cpfp_pkg::PH_NODE: begin
                    node_left = node_left - 8'd1;
                    if (node_left == 8'd0) begin
                        // fragments go straight to payload after the node name
                        complete = (kind == cpfp_pkg::PK_MIDDLE || kind == cpfp_pkg::PK_END);
                        enter_phase(complete ? cpfp_pkg::PH_PAY : cpfp_pkg::PH_AKIND);
                    end else begin
                        bump_index();
                    end
                end
                cpfp_pkg::PH_AKIND:
                    enter_phase((b == 8'd0) ? cpfp_pkg::PH_ANUM : cpfp_pkg::PH_ALEN);
                cpfp_pkg::PH_ANUM: begin
                    if (idx == cpfp_pkg::WORD_LAST_IDX) enter_phase(cpfp_pkg::PH_TYPE);
                    else bump_index();
                end
                cpfp_pkg::PH_ALEN: begin
                    addr_left = b;
                    enter_phase((b == 8'd0) ? cpfp_pkg::PH_TYPE : cpfp_pkg::PH_ANAME);
                end
                cpfp_pkg::PH_ANAME: begin
                    addr_left = addr_left - 8'd1;
                    if (addr_left == 8'd0) enter_phase(cpfp_pkg::PH_TYPE);
                    else bump_index();
                end
                cpfp_pkg::PH_TYPE: begin
                    if (idx == cpfp_pkg::WORD_LAST_IDX) begin
                        complete = (kind == cpfp_pkg::PK_SINGLE);
                        enter_phase(complete ? cpfp_pkg::PH_PAY : cpfp_pkg::PH_SIZE);
                    end else begin
                        bump_index();
                    end
                end
                cpfp_pkg::PH_SIZE: begin
                    if (idx == cpfp_pkg::WORD_LAST_IDX) begin
                        complete = 1'b1;
                        enter_phase(cpfp_pkg::PH_IGN);
                    end else begin
                        bump_index();
                    end
                end
                default: begin
                    complete = 1'b1;
                    bump_index();
                end
            endcase

            is_frag = (kind == cpfp_pkg::PK_MIDDLE || kind == cpfp_pkg::PK_END);
            if (last) begin
                if (field == cpfp_pkg::PH_NLEN && b == 8'd0)
                    r.error_code = is_frag ? cpfp_pkg::ERR_NODE : cpfp_pkg::ERR_TRUNC;
                else if (held_err == cpfp_pkg::ERR_KIND)
                    r.error_code = cpfp_pkg::ERR_KIND;
                else if (held_err == cpfp_pkg::ERR_NODE)
                    // single/first ending right after a zero node length counts as truncated
                    r.error_code = (!is_frag && field == cpfp_pkg::PH_IGN && idx == 8'd0) ?
                                   cpfp_pkg::ERR_TRUNC : cpfp_pkg::ERR_NODE;
                else
                    r.error_code = complete ? cpfp_pkg::ERR_OK : cpfp_pkg::ERR_TRUNC;
            end

            r.field_code    = field;
            r.byte_value    = b;
            r.field_index   = idx;
            r.packet_kind   = kind;
            r.end_of_packet = last;
            if (last)
                clear_state();
            return r;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            expected_fields.push_back(classify_byte(b, last));
        endfunction

        function void diff_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_field(cpfp_pkg::t_result got);
            cpfp_pkg::t_result want;
            if (expected_fields.size() == 0) begin
                $error("unexpected result transaction: field_code %0d byte_value 0x%0h",
                       got.field_code, got.byte_value);
                mismatch_count++;
                return;
            end
            want = expected_fields.pop_front();
            diff_field("field_code",    32'(want.field_code),    32'(got.field_code));
            diff_field("byte_value",    32'(want.byte_value),    32'(got.byte_value));
            diff_field("field_index",   32'(want.field_index),   32'(got.field_index));
            diff_field("word_value",    want.word_value,         got.word_value);
            diff_field("word_done",     32'(want.word_done),     32'(got.word_done));
            diff_field("packet_kind",   32'(want.packet_kind),   32'(got.packet_kind));
            diff_field("end_of_packet", 32'(want.end_of_packet), 32'(got.end_of_packet));
            diff_field("error_code",    32'(want.error_code),    32'(got.error_code));
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;

    t_byte_item   stim[$];
    parse_checker tracker = new();

    cpfp_in_if  in_ch();
    cpfp_out_if out_ch();

    cluster_packet_field_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Builds one packet body; tail_len is payload, or ignored bytes for first/unknown kinds.
    // cut > 0 truncates the packet to that many bytes if the body is longer.
    task automatic add_packet(input logic [7:0] kind_code, input int node_size,
                              input bit str_addr, input int addr_size, input int tail_len,
                              input int cut);
        logic [7:0] body[$];
        int         keep;
        int         i;
        body.push_back(kind_code);
        if (kind_code == cpfp_pkg::KIND_SINGLE_CODE || kind_code == cpfp_pkg::KIND_FIRST_CODE ||
            kind_code == cpfp_pkg::KIND_MIDDLE_CODE || kind_code == cpfp_pkg::KIND_END_CODE) begin
            repeat (4) body.push_back(8'($urandom));
            body.push_back(8'(node_size));
            repeat (node_size) body.push_back(8'($urandom));
            if (kind_code == cpfp_pkg::KIND_SINGLE_CODE ||
                kind_code == cpfp_pkg::KIND_FIRST_CODE) begin
                if (str_addr) begin
                    body.push_back(8'($urandom_range(1, 255)));
                    body.push_back(8'(addr_size));
                    repeat (addr_size) body.push_back(8'($urandom));
                end else begin
                    body.push_back(8'h00);
                    repeat (4) body.push_back(8'($urandom));
                end
                repeat (4) body.push_back(8'($urandom));
                if (kind_code == cpfp_pkg::KIND_FIRST_CODE)
                    repeat (4) body.push_back(8'($urandom));
            end
        end
        repeat (tail_len) body.push_back(8'($urandom));
        keep = (cut > 0 && cut < body.size()) ? cut : body.size();
        for (i = 0; i < keep; i++)
            stim.push_back('{data: body[i], last: (i == keep - 1)});
    endtask

    task automatic drive_stream();
        int pos;
        int burst;
        int gap;
        int n;
        pos = 0;
        while (pos < stim.size()) begin
            burst = $urandom_range(1, 32);
            for (n = 0; n < burst && pos < stim.size(); n++) begin
                in_ch.valid     <= 1'b1;
                in_ch.data_byte <= stim[pos].data;
                in_ch.last_byte <= stim[pos].last;
                do @(posedge i_clk); while (!in_ch.ready);
                pos++;
            end
            if ($urandom_range(0, 9) < 3)
                gap = 0;
            else if ($urandom_range(0, 19) == 0)
                gap = $urandom_range(8, 20);
            else
                gap = $urandom_range(1, 4);
            if (gap > 0) begin
                in_ch.valid     <= 1'b0;
                in_ch.data_byte <= 8'($urandom);
                in_ch.last_byte <= 1'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int         base;
        int         pick;
        logic [7:0] code;
        int         node_size;
        int         addr_size;
        int         tail_len;
        int         cut;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;

        // directed packets
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 3, 1'b0, 0, 2, 0);
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 1, 1'b1, 4, 0, 0);
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 2, 1'b1, 0, 1, 0);   // empty address name
        add_packet(cpfp_pkg::KIND_FIRST_CODE, 2, 1'b0, 0, 2, 0);    // trailing bytes ignored
        add_packet(cpfp_pkg::KIND_MIDDLE_CODE, 2, 1'b0, 0, 3, 0);
        add_packet(cpfp_pkg::KIND_END_CODE, 1, 1'b0, 0, 0, 0);
        add_packet(8'hff, 0, 1'b0, 0, 3, 0);                        // unknown kind
        add_packet(8'h43, 0, 1'b0, 0, 0, 0);
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 0, 1'b0, 0, 0, 6);   // zero node length, short
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 0, 1'b0, 0, 0, 7);
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 0, 1'b0, 0, 0, 0);
        add_packet(cpfp_pkg::KIND_MIDDLE_CODE, 0, 1'b0, 0, 2, 6);
        add_packet(cpfp_pkg::KIND_END_CODE, 0, 1'b0, 0, 2, 0);
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 2, 1'b0, 0, 2, 14);  // cut inside type
        add_packet(cpfp_pkg::KIND_MIDDLE_CODE, 4, 1'b0, 0, 2, 8);   // cut inside node name
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 0, 1'b0, 0, 0, 1);   // kind byte only
        add_packet(cpfp_pkg::KIND_END_CODE, 1, 1'b0, 0, 258, 0);    // index saturates
        add_packet(cpfp_pkg::KIND_MIDDLE_CODE, 255, 1'b0, 0, 0, 12); // longest node name, cut
        add_packet(cpfp_pkg::KIND_SINGLE_CODE, 1, 1'b1, 255, 0, 20); // longest address, cut

        base = stim.size();
        while (stim.size() < base + RANDOM_BYTES) begin
            pick      = $urandom_range(0, 99);
            node_size = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(1, 6);
            addr_size = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 5);
            tail_len  = ($urandom_range(0, 29) == 0) ? $urandom_range(11, 40)
                                                     : $urandom_range(0, 10);
            cut       = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 20) : 0;
            if (pick < 10) begin
                // noise: any kind byte, mostly cut short
                code = 8'($urandom);
                cut  = $urandom_range(1, 10);
            end else if (pick < 18) begin
                do code = 8'($urandom);
                while (code == cpfp_pkg::KIND_SINGLE_CODE || code == cpfp_pkg::KIND_FIRST_CODE ||
                       code == cpfp_pkg::KIND_MIDDLE_CODE || code == cpfp_pkg::KIND_END_CODE);
            end else begin
                case ($urandom_range(0, 3))
                    0:       code = cpfp_pkg::KIND_SINGLE_CODE;
                    1:       code = cpfp_pkg::KIND_FIRST_CODE;
                    2:       code = cpfp_pkg::KIND_MIDDLE_CODE;
                    default: code = cpfp_pkg::KIND_END_CODE;
                endcase
                if ($urandom_range(0, 19) == 0)
                    node_size = 0;
            end
            add_packet(code, node_size, 1'($urandom), addr_size, tail_len, cut);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_stream();

        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (4) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: random stall modes per stretch, plus long hold-offs so the input side backs up.
    initial begin : result_sink
        t_rx_mode mode;
        int       span;
        int       hold;
        int       holdoffs;
        bit       toggle;
        holdoffs = 0;
        toggle   = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            if ((holdoffs == 0 && cycle_count >= 300) ||
                (holdoffs == 1 && cycle_count >= 1200)) begin
                holdoffs++;
                hold = 0;
                while (hold < 100) begin
                    @(posedge i_clk);
                    out_ch.ready <= 1'b0;
                    hold++;
                end
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(posedge i_clk);
                toggle = ~toggle;
                case (mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_TOGGLE: out_ch.ready <= toggle;
                    default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Sample both channels at the edge; a transaction is valid && ready there.
    always @(posedge i_clk) begin : monitor
        cpfp_pkg::t_result seen;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_byte(in_ch.data_byte, in_ch.last_byte);
            if (out_ch.valid && out_ch.ready) begin
                seen.field_code    = out_ch.field_code;
                seen.byte_value    = out_ch.byte_value;
                seen.field_index   = out_ch.field_index;
                seen.word_value    = out_ch.word_value;
                seen.word_done     = out_ch.word_done;
                seen.packet_kind   = out_ch.packet_kind;
                seen.end_of_packet = out_ch.end_of_packet;
                seen.error_code    = out_ch.error_code;
                tracker.check_field(seen);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
